FILE: design/csq_pkg.sv
// csq_pkg: shared widths, mode codes and the statistics record for the
// coefficient statistics and int8 quantizer; no dependencies
package csq_pkg;

    localparam int COEFS      = 13;
    localparam int POS_W      = 4;
    localparam int MODE_W     = 2;
    localparam int COEF_W     = 24;
    localparam int SCALE_W    = 16;
    localparam int Q_W        = 8;
    localparam int SUM_W      = 48;
    localparam int SUMSQ_W    = 64;
    localparam int FRAME_W    = 32;
    localparam int PROD_W     = COEF_W + SCALE_W;
    localparam int SQR_W      = 2 * COEF_W;
    localparam int FRAC_SHIFT = 20;
    localparam int Q_LIMIT    = 127;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_COEF  = 2'd0;
    localparam mode_t MODE_CLEAR = 2'd1;
    localparam mode_t MODE_SCALE = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0]          pos;
        logic signed [COEF_W-1:0]  run_min;
        logic signed [COEF_W-1:0]  run_max;
        logic signed [SUM_W-1:0]   run_sum;
        logic [SUMSQ_W-1:0]        run_sumsq;
        logic [FRAME_W-1:0]        frames;
        logic                      fend;
    } stat_t;

endpackage

FILE: design/csq_if.sv
// csq_if: valid/ready channel interfaces for input items, result items and
// the configuration write; depends on csq_pkg
interface csq_in_if import csq_pkg::*;;
    logic                      valid;
    logic                      ready;
    mode_t                     mode;
    logic signed [COEF_W-1:0]  coef_value;
    logic [POS_W-1:0]          scale_slot;
    logic signed [SCALE_W-1:0] scale_value;

    modport source (output valid, mode, coef_value, scale_slot, scale_value, input ready);
    modport sink (input valid, mode, coef_value, scale_slot, scale_value, output ready);
endinterface

interface csq_out_if import csq_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [Q_W-1:0]     quantized;
    logic [POS_W-1:0]          coef_position;
    logic signed [COEF_W-1:0]  running_min;
    logic signed [COEF_W-1:0]  running_max;
    logic signed [SUM_W-1:0]   running_sum;
    logic [SUMSQ_W-1:0]        running_sumsq;
    logic [FRAME_W-1:0]        frame_total;
    logic                      frame_end;

    modport source (output valid, quantized, coef_position, running_min, running_max,
                    running_sum, running_sumsq, frame_total, frame_end, input ready);
    modport sink (input valid, quantized, coef_position, running_min, running_max,
                  running_sum, running_sumsq, frame_total, frame_end, output ready);
endinterface

interface csq_cfg_if;
    logic valid;
    logic ready;
    logic stats_enable;

    modport source (output valid, stats_enable, input ready);
    modport sink (input valid, stats_enable, output ready);
endinterface

FILE: design/coef_stats_and_int8_quantizer.sv
// coef_stats_and_int8_quantizer: top level with input stage, squaring, result
// register and handshake; depends on csq_pkg, csq_if, csq_quant, csq_stats
//
// Takes one item per clock unless the result side stalls, and returns one
// result per item from the output register. The rate of one item per cycle
// is set by the read-modify-write of one position's table entry, which
// completes in the cycle an item leaves the input stage; the square of the
// coefficient is formed as the item enters. A finished result waits in the
// output register while the next item is taken. stats_enable comes up as 1.
module coef_stats_and_int8_quantizer
    import csq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    csq_cfg_if.sink    cfg,
    csq_in_if.sink     item,
    csq_out_if.source  result
);

    logic                      stats_enable_reg;
    logic                      s1_valid_reg;
    mode_t                     s1_mode_reg;
    logic signed [COEF_W-1:0]  s1_coef_reg;
    logic [SQR_W-1:0]          s1_sq_reg;
    logic [POS_W-1:0]          s1_slot_reg;
    logic signed [SCALE_W-1:0] s1_scale_reg;
    logic                      out_valid_reg;
    logic signed [Q_W-1:0]     q_reg;
    stat_t                     stat_reg;

    logic                      adv;
    logic                      take;
    logic signed [SQR_W-1:0]   sq_next;
    logic signed [SCALE_W-1:0] cur_scale;
    logic signed [Q_W-1:0]     q_next;
    stat_t                     stat_next;

    assign adv        = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || adv;
    assign take       = item.valid && item.ready;
    assign cfg.ready  = 1'b1;
    assign sq_next    = SQR_W'(item.coef_value) * SQR_W'(item.coef_value);

    csq_quant u_quant (
        .enable    (s1_mode_reg == MODE_COEF),
        .coef      (s1_coef_reg),
        .scale     (cur_scale),
        .quantized (q_next)
    );

    csq_stats u_stats (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (adv),
        .stats_enable (stats_enable_reg),
        .mode         (s1_mode_reg),
        .coef         (s1_coef_reg),
        .coef_sq      (s1_sq_reg),
        .scale_slot   (s1_slot_reg),
        .scale_value  (s1_scale_reg),
        .cur_scale    (cur_scale),
        .stat         (stat_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_enable_reg <= 1'b1;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                stats_enable_reg <= cfg.stats_enable;
            end
            if (item.ready)
            begin
                s1_valid_reg <= item.valid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_mode_reg  <= item.mode;
            s1_coef_reg  <= item.coef_value;
            s1_sq_reg    <= sq_next;
            s1_slot_reg  <= item.scale_slot;
            s1_scale_reg <= item.scale_value;
        end
        if (adv)
        begin
            q_reg    <= q_next;
            stat_reg <= stat_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.quantized     = q_reg;
    assign result.coef_position = stat_reg.pos;
    assign result.running_min   = stat_reg.run_min;
    assign result.running_max   = stat_reg.run_max;
    assign result.running_sum   = stat_reg.run_sum;
    assign result.running_sumsq = stat_reg.run_sumsq;
    assign result.frame_total   = stat_reg.frames;
    assign result.frame_end     = stat_reg.fend;

endmodule

FILE: design/csq_quant.sv
// csq_quant: scales one coefficient, rounds half away from zero and clips to
// plus or minus 127; depends on csq_pkg
module csq_quant
    import csq_pkg::*;
(
    input  logic                      enable,
    input  logic signed [COEF_W-1:0]  coef,
    input  logic signed [SCALE_W-1:0] scale,
    output logic signed [Q_W-1:0]     quantized
);

    logic signed [PROD_W-1:0] prod;
    logic                     neg;
    logic [PROD_W-1:0]        mag;
    logic [PROD_W-1:0]        rounded;
    logic [Q_W-1:0]           clipped;

    always_comb
    begin
        prod    = PROD_W'(coef) * PROD_W'(scale);
        neg     = prod[PROD_W-1];
        mag     = neg ? PROD_W'(-prod) : PROD_W'(prod);
        rounded = (mag + (PROD_W'(1) << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
        clipped = (rounded > PROD_W'(Q_LIMIT)) ? Q_W'(Q_LIMIT) : rounded[Q_W-1:0];
        if (!enable)
        begin
            quantized = '0;
        end
        else
        begin
            quantized = neg ? $signed(Q_W'(-clipped)) : $signed(clipped);
        end
    end

endmodule

FILE: design/csq_stats.sv
// csq_stats: scale table, per-position statistics tables, seen bits, frame
// count and position counter; depends on csq_pkg
module csq_stats
    import csq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic                      stats_enable,
    input  mode_t                     mode,
    input  logic signed [COEF_W-1:0]  coef,
    input  logic [SQR_W-1:0]          coef_sq,
    input  logic [POS_W-1:0]          scale_slot,
    input  logic signed [SCALE_W-1:0] scale_value,
    output logic signed [SCALE_W-1:0] cur_scale,
    output stat_t                     stat
);

    logic signed [SCALE_W-1:0] scale_reg [COEFS];
    logic signed [COEF_W-1:0]  min_reg   [COEFS];
    logic signed [COEF_W-1:0]  max_reg   [COEFS];
    logic signed [SUM_W-1:0]   sum_reg   [COEFS];
    logic [SUMSQ_W-1:0]        sumsq_reg [COEFS];
    logic [COEFS-1:0]          seen_reg;
    logic [FRAME_W-1:0]        frames_reg;
    logic [POS_W-1:0]          position_reg;

    logic [FRAME_W-1:0]        frames_next;
    logic [POS_W-1:0]          position_next;
    logic                      is_coef;
    logic                      upd;
    logic                      fend;
    logic signed [COEF_W-1:0]  min_next;
    logic signed [COEF_W-1:0]  max_next;
    logic signed [SUM_W-1:0]   sum_next;
    logic [SUMSQ_W-1:0]        sumsq_next;
    logic signed [SUM_W:0]     sum_wide;
    logic [SUMSQ_W:0]          sumsq_wide;

    always_comb
    begin
        is_coef   = (mode == MODE_COEF);
        upd       = is_coef && stats_enable;
        fend      = (position_reg == POS_W'(COEFS - 1));
        cur_scale = scale_reg[position_reg];

        min_next = min_reg[position_reg];
        max_next = max_reg[position_reg];
        if (!seen_reg[position_reg] || (coef < min_reg[position_reg]))
        begin
            min_next = coef;
        end
        if (!seen_reg[position_reg] || (coef > max_reg[position_reg]))
        begin
            max_next = coef;
        end

        sum_wide = (SUM_W+1)'(sum_reg[position_reg]) + (SUM_W+1)'(coef);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end

        sumsq_wide = {1'b0, sumsq_reg[position_reg]} + (SUMSQ_W+1)'(coef_sq);
        sumsq_next = sumsq_wide[SUMSQ_W] ? {SUMSQ_W{1'b1}} : sumsq_wide[SUMSQ_W-1:0];

        frames_next   = frames_reg;
        position_next = position_reg;
        case (mode)
            MODE_COEF:
            begin
                if (upd && fend && (frames_reg != {FRAME_W{1'b1}}))
                begin
                    frames_next = frames_reg + FRAME_W'(1);
                end
                position_next = fend ? '0 : position_reg + POS_W'(1);
            end
            MODE_CLEAR:
            begin
                frames_next   = '0;
                position_next = '0;
            end
            default:
            begin
                frames_next   = frames_reg;
                position_next = position_reg;
            end
        endcase

        stat        = '0;
        stat.frames = frames_next;
        if (is_coef)
        begin
            stat.pos       = position_reg;
            stat.fend      = fend;
            stat.run_min   = upd ? min_next : min_reg[position_reg];
            stat.run_max   = upd ? max_next : max_reg[position_reg];
            stat.run_sum   = upd ? sum_next : sum_reg[position_reg];
            stat.run_sumsq = upd ? sumsq_next : sumsq_reg[position_reg];
        end
        else
        begin
            stat.pos = position_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEFS; i++)
            begin
                scale_reg[i] <= '0;
                min_reg[i]   <= '0;
                max_reg[i]   <= '0;
                sum_reg[i]   <= '0;
                sumsq_reg[i] <= '0;
            end
            seen_reg     <= '0;
            frames_reg   <= '0;
            position_reg <= '0;
        end
        else if (step)
        begin
            frames_reg   <= frames_next;
            position_reg <= position_next;
            if (upd)
            begin
                min_reg[position_reg]   <= min_next;
                max_reg[position_reg]   <= max_next;
                sum_reg[position_reg]   <= sum_next;
                sumsq_reg[position_reg] <= sumsq_next;
                seen_reg[position_reg]  <= 1'b1;
            end
            if (mode == MODE_CLEAR)
            begin
                for (int i = 0; i < COEFS; i++)
                begin
                    min_reg[i]   <= '0;
                    max_reg[i]   <= '0;
                    sum_reg[i]   <= '0;
                    sumsq_reg[i] <= '0;
                end
                seen_reg <= '0;
            end
            if ((mode == MODE_SCALE) && (scale_slot < POS_W'(COEFS)))
            begin
                scale_reg[scale_slot] <= scale_value;
            end
        end
    end

endmodule

FILE: design/csq_checker.sv
// csq_checker: port-level checks on the result channel of the top level,
// attached by bind; depends on csq_pkg and coef_stats_and_int8_quantizer
module csq_checker
    import csq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [Q_W-1:0]    quantized,
    input logic [POS_W-1:0]         coef_position,
    input logic signed [COEF_W-1:0] running_min,
    input logic signed [COEF_W-1:0] running_max,
    input logic                     frame_end
);

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quantized != -8'sd128)
        else $error("quantized value outside clip range");

    a_fend_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> coef_position == POS_W'(COEFS - 1))
        else $error("frame end at wrong position");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> running_min <= running_max)
        else $error("running minimum above running maximum");

endmodule

bind coef_stats_and_int8_quantizer csq_checker u_csq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .quantized     (result.quantized),
    .coef_position (result.coef_position),
    .running_min   (result.running_min),
    .running_max   (result.running_max),
    .frame_end     (result.frame_end)
);
